FILE: hdl/ydpcm_pkg.sv
// Shared types, constants and colour-conversion coefficients for the YCbCr 4:2:0 DPCM encoder.
package ydpcm_pkg;

    // Default for the largest supported row length
    localparam int DEF_MAX_WIDTH = 4096;

    // Field and port widths
    localparam int PIX_W      = 8;
    localparam int RES_W      = 9;
    localparam int SHIFT_W    = 3;
    localparam int IWIDTH_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 25;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_LUMA_SHIFT  = 2'd1,
        CFG_CB_SHIFT    = 2'd2,
        CFG_CR_SHIFT    = 2'd3
    } t_cfg_idx;

    localparam logic [IWIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;

    // BT.601 full-range coefficients, Q16
    localparam logic [15:0] C_Y_R  = 16'd19595;
    localparam logic [15:0] C_Y_G  = 16'd38470;
    localparam logic [15:0] C_Y_B  = 16'd7471;
    localparam logic [15:0] C_CB_R = 16'd11058;
    localparam logic [15:0] C_CB_G = 16'd21710;
    localparam logic [15:0] C_CB_B = 16'd32768;
    localparam logic [15:0] C_CR_R = 16'd32768;
    localparam logic [15:0] C_CR_G = 16'd27439;
    localparam logic [15:0] C_CR_B = 16'd5329;
    // 128 in Q16, chroma offset
    localparam logic [SUM_W-1:0] CHROMA_OFS = 25'd8388608;

    typedef struct packed {
        logic [IWIDTH_W-1:0] image_width;
        logic [SHIFT_W-1:0]  luma_shift;
        logic [SHIFT_W-1:0]  cb_shift;
        logic [SHIFT_W-1:0]  cr_shift;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } t_rgb;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic             frame_start;
    } t_ycc;

endpackage

FILE: hdl/ydpcm_csc.sv
// Two-stage RGB to YCbCr converter: registered products, then registered sums.
module ydpcm_csc
    import ydpcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_rgb i_pix,
    output logic o_valid,
    input  logic i_stall,
    output t_ycc o_ycc
);

    logic              r_p_valid;
    logic              r_p_fs;
    logic [PROD_W-1:0] r_y_r, r_y_g, r_y_b;
    logic [PROD_W-1:0] r_cb_r, r_cb_g, r_cb_b;
    logic [PROD_W-1:0] r_cr_r, r_cr_g, r_cr_b;
    logic              r_c_valid;
    t_ycc              r_ycc;

    logic              s2_adv;
    logic              s1_adv;
    logic [SUM_W-1:0]  n_y_sum;
    logic [SUM_W-1:0]  n_cb_sum;
    logic [SUM_W-1:0]  n_cr_sum;

    // Stage advance: a stage moves when it is empty or its successor moves
    assign s2_adv  = !r_c_valid || !i_stall;
    assign s1_adv  = !r_p_valid || s2_adv;
    assign o_stall = !s1_adv;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (s1_adv) begin
            r_p_valid <= i_valid;
        end
        if (s1_adv && i_valid) begin
            r_p_fs <= i_pix.frame_start;
            r_y_r  <= PROD_W'(i_pix.red)   * PROD_W'(C_Y_R);
            r_y_g  <= PROD_W'(i_pix.green) * PROD_W'(C_Y_G);
            r_y_b  <= PROD_W'(i_pix.blue)  * PROD_W'(C_Y_B);
            r_cb_r <= PROD_W'(i_pix.red)   * PROD_W'(C_CB_R);
            r_cb_g <= PROD_W'(i_pix.green) * PROD_W'(C_CB_G);
            r_cb_b <= PROD_W'(i_pix.blue)  * PROD_W'(C_CB_B);
            r_cr_r <= PROD_W'(i_pix.red)   * PROD_W'(C_CR_R);
            r_cr_g <= PROD_W'(i_pix.green) * PROD_W'(C_CR_G);
            r_cr_b <= PROD_W'(i_pix.blue)  * PROD_W'(C_CR_B);
        end
    end

    // Weighted sums; chroma sums never go negative, so the modulo result is exact
    always_comb begin
        n_y_sum  = SUM_W'(r_y_r) + SUM_W'(r_y_g) + SUM_W'(r_y_b);
        n_cb_sum = CHROMA_OFS + SUM_W'(r_cb_b) - SUM_W'(r_cb_r) - SUM_W'(r_cb_g);
        n_cr_sum = CHROMA_OFS + SUM_W'(r_cr_r) - SUM_W'(r_cr_g) - SUM_W'(r_cr_b);
    end

    // Sum stage, Q16 truncated to integer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (s2_adv) begin
            r_c_valid <= r_p_valid;
        end
        if (s2_adv && r_p_valid) begin
            r_ycc.y           <= n_y_sum[23:16];
            r_ycc.cb          <= n_cb_sum[23:16];
            r_ycc.cr          <= n_cr_sum[23:16];
            r_ycc.frame_start <= r_p_fs;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ycc   = r_ycc;

endmodule

FILE: hdl/ydpcm_dpcm.sv
// Closed-loop DPCM stage with row/column tracking, 4:2:0 chroma selection and result register.
module ydpcm_dpcm
    import ydpcm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_ycc                    i_ycc,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [RES_W-1:0] o_luma_residual,
    output logic signed [RES_W-1:0] o_cb_residual,
    output logic signed [RES_W-1:0] o_cr_residual,
    output logic                    o_chroma_valid
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]           r_col;
    logic                    r_odd;
    logic [PIX_W-1:0]        r_prev_y;
    logic [PIX_W-1:0]        r_prev_cb;
    logic [PIX_W-1:0]        r_prev_cr;
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_luma;
    logic signed [RES_W-1:0] r_cb;
    logic signed [RES_W-1:0] r_cr;
    logic                    r_chroma;

    logic                    adv;
    logic                    fire;
    logic [CW-1:0]           col_cur;
    logic                    odd_cur;
    logic                    first;
    logic                    chroma;
    logic [CW:0]             col_inc;
    logic [31:0]             width_raw;
    logic [31:0]             width_eff;
    logic                    wrap;
    logic [CW-1:0]           n_col;
    logic                    n_odd;
    logic [RES_W+PIX_W-1:0]  y_step;
    logic [RES_W+PIX_W-1:0]  cb_step;
    logic [RES_W+PIX_W-1:0]  cr_step;

    // One channel step: {residual, new reconstruction}
    function automatic logic [RES_W+PIX_W-1:0] dpcm_step(
        input logic [PIX_W-1:0]   sample,
        input logic [PIX_W-1:0]   prev,
        input logic [SHIFT_W-1:0] sh,
        input logic               is_first
    );
        logic signed [RES_W-1:0] diff;
        logic signed [RES_W-1:0] res;
        logic        [RES_W-1:0] back;
        logic        [PIX_W-1:0] rec;
        diff = $signed({1'b0, sample}) - $signed({1'b0, prev});
        res  = diff >>> sh;
        back = RES_W'(res << sh);
        rec  = prev + back[PIX_W-1:0];
        if (is_first) begin
            res = $signed({1'b0, sample});
            rec = sample;
        end
        return {res, rec};
    endfunction

    assign adv     = !r_out_valid || !i_stall;
    assign fire    = adv && i_valid;
    assign o_stall = !adv;

    // Position of this pixel; a frame start forces row 0, column 0
    always_comb begin
        col_cur = i_ycc.frame_start ? '0 : r_col;
        odd_cur = i_ycc.frame_start ? 1'b0 : r_odd;
        first   = (col_cur == '0);
        chroma  = !odd_cur && !col_cur[0];
    end

    // Effective width clamped to 1..MAX_WIDTH, and the column step
    always_comb begin
        width_raw = 32'(i_cfg.image_width);
        if (width_raw == 32'd0) begin
            width_eff = 32'd1;
        end else if (width_raw > 32'(MAX_WIDTH)) begin
            width_eff = 32'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
        col_inc = {1'b0, col_cur} + (CW+1)'(1);
        wrap    = 32'(col_inc) >= width_eff;
        n_col   = wrap ? '0 : col_inc[CW-1:0];
        n_odd   = odd_cur ^ wrap;
    end

    // Per-channel DPCM
    always_comb begin
        y_step  = dpcm_step(i_ycc.y,  r_prev_y,  i_cfg.luma_shift, first);
        cb_step = dpcm_step(i_ycc.cb, r_prev_cb, i_cfg.cb_shift,   first);
        cr_step = dpcm_step(i_ycc.cr, r_prev_cr, i_cfg.cr_shift,   first);
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_odd       <= 1'b0;
            r_prev_y    <= '0;
            r_prev_cb   <= '0;
            r_prev_cr   <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= i_valid;
            end
            if (fire) begin
                r_col    <= n_col;
                r_odd    <= n_odd;
                r_prev_y <= y_step[PIX_W-1:0];
                // chroma predictors hold on pixels without chroma
                if (chroma) begin
                    r_prev_cb <= cb_step[PIX_W-1:0];
                    r_prev_cr <= cr_step[PIX_W-1:0];
                end
            end
        end
        if (fire) begin
            r_luma   <= $signed(y_step[RES_W+PIX_W-1:PIX_W]);
            r_cb     <= chroma ? $signed(cb_step[RES_W+PIX_W-1:PIX_W]) : '0;
            r_cr     <= chroma ? $signed(cr_step[RES_W+PIX_W-1:PIX_W]) : '0;
            r_chroma <= chroma;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_luma_residual = r_luma;
    assign o_cb_residual   = r_cb;
    assign o_cr_residual   = r_cr;
    assign o_chroma_valid  = r_chroma;

endmodule

FILE: hdl/ycbcr_420_lossy_dpcm_encoder.sv
// Path: a pixel passes the input register, product stage, sum stage and DPCM stage in order.
// Throughput: one pixel per cycle while the output is not stalled; each of these stages
// holds one transaction, and an empty stage still takes a pixel while the output waits.
// The DPCM reconstruction loop (subtract, shift, add) closes within the last stage.
// Reset (synchronous, active low) empties the pipeline, clears row, column and predictors,
// and loads the register defaults (width 640, all shifts 0).
module ycbcr_420_lossy_dpcm_encoder
    import ydpcm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [PIX_W-1:0]        i_red,
    input  logic [PIX_W-1:0]        i_green,
    input  logic [PIX_W-1:0]        i_blue,
    input  logic                    i_frame_start,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [RES_W-1:0] o_luma_residual,
    output logic signed [RES_W-1:0] o_cb_residual,
    output logic signed [RES_W-1:0] o_cr_residual,
    output logic                    o_chroma_valid
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_rgb r_in;

    logic in_adv;
    logic csc_stall;
    logic csc_valid;
    t_ycc csc_ycc;
    logic dpcm_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= RST_IMAGE_WIDTH;
            r_cfg.luma_shift  <= '0;
            r_cfg.cb_shift    <= '0;
            r_cfg.cr_shift    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_cfg.image_width <= i_cfg_data[IWIDTH_W-1:0];
                CFG_LUMA_SHIFT:  r_cfg.luma_shift  <= i_cfg_data[SHIFT_W-1:0];
                CFG_CB_SHIFT:    r_cfg.cb_shift    <= i_cfg_data[SHIFT_W-1:0];
                CFG_CR_SHIFT:    r_cfg.cr_shift    <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    assign in_adv     = !r_in_valid || !csc_stall;
    assign o_in_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
        if (in_adv && i_in_valid) begin
            r_in.red         <= i_red;
            r_in.green       <= i_green;
            r_in.blue        <= i_blue;
            r_in.frame_start <= i_frame_start;
        end
    end

    ydpcm_csc u_csc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_stall (csc_stall),
        .i_pix   (r_in),
        .o_valid (csc_valid),
        .i_stall (dpcm_stall),
        .o_ycc   (csc_ycc)
    );

    ydpcm_dpcm #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpcm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (csc_valid),
        .o_stall         (dpcm_stall),
        .i_ycc           (csc_ycc),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_luma_residual (o_luma_residual),
        .o_cb_residual   (o_cb_residual),
        .o_cr_residual   (o_cr_residual),
        .o_chroma_valid  (o_chroma_valid)
    );

endmodule

FILE: hdl/ydpcm_checker.sv
// Port-level assertions for the encoder, bound to the top level.
module ydpcm_checker
    import ydpcm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_stall,
    input logic                    o_out_valid,
    input logic signed [RES_W-1:0] o_luma_residual,
    input logic signed [RES_W-1:0] o_cb_residual,
    input logic signed [RES_W-1:0] o_cr_residual,
    input logic                    o_chroma_valid
);

    localparam logic [RES_W-1:0] RES_MIN_BAD = 9'h100;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_luma_residual)
            && $stable(o_cb_residual) && $stable(o_cr_residual)
            && $stable(o_chroma_valid))
        else $error("stalled result changed");

    // Chroma residuals are zero on pixels without chroma
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chroma_valid |-> o_cb_residual == '0 && o_cr_residual == '0)
        else $error("chroma residual set on a pixel without chroma");

    // Residuals stay within -255..255
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_luma_residual != RES_MIN_BAD && o_cb_residual != RES_MIN_BAD
            && o_cr_residual != RES_MIN_BAD)
        else $error("residual out of range");

endmodule

bind ycbcr_420_lossy_dpcm_encoder ydpcm_checker u_ydpcm_checker (.*);
